[rtl/tga_rle_pkg.sv]
// Shared constants, codes and types of the Targa run-length pixel decoder.
package tga_rle_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	// input item modes
	localparam logic [1:0] MODE_PAL_WR = 2'd0;
	localparam logic [1:0] MODE_DATA   = 2'd1;
	localparam logic [1:0] MODE_START  = 2'd2;

	// pixel formats
	localparam logic [1:0] FMT_GREY = 2'd0;
	localparam logic [1:0] FMT_PAL  = 2'd1;
	localparam logic [1:0] FMT_BGR  = 2'd2;
	localparam logic [1:0] FMT_BGRA = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_FORMAT = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	localparam logic [1:0] FMT_RESET = FMT_BGR;

	// packet header fields
	localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
	localparam logic [7:0] HDR_RUN_MASK   = 8'h80;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// palette port request, issued in the cycle an item is taken
	typedef struct packed {
		logic       wr_en;
		logic [7:0] wr_index;
		rgb_t       wr_color;
		logic       rd_en;
		logic [7:0] rd_index;
	} pal_req_t;

endpackage

[rtl/tga_rle_if.sv]
// Valid/ready channel interfaces: stream in, pixel results out, configuration writes.
interface tga_rle_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  data_byte;
	logic [7:0]  palette_index;
	logic [23:0] palette_color;

	modport source (output valid, mode, data_byte, palette_index, palette_color, input ready);
	modport sink   (input valid, mode, data_byte, palette_index, palette_color, output ready);
endinterface

interface tga_rle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] repeat_count;
	logic       image_done;
	logic       overflow_error;

	modport source (output valid, red, green, blue, repeat_count, image_done, overflow_error,
		input ready);
	modport sink   (input valid, red, green, blue, repeat_count, image_done, overflow_error,
		output ready);
endinterface

interface tga_rle_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/tga_rle_palette.sv]
// Palette memory: one write and one registered read per cycle, cleared by valid bits.
module tga_rle_palette
	import tga_rle_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  pal_req_t req,
	output rgb_t     rd_color
);

	rgb_t                     mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] entry_vld_q;
	rgb_t                     rd_data_q;
	logic                     rd_hit_q;
	logic                     wr_ok;
	logic                     rd_ok;
	logic [PAL_AW-1:0]        wr_addr;
	logic [PAL_AW-1:0]        rd_addr;

	// indexes past the table: writes dropped, lookups give black
	assign wr_ok   = req.wr_en && ({1'b0, req.wr_index} < 9'(PALETTE_DEPTH));
	assign rd_ok   = {1'b0, req.rd_index} < 9'(PALETTE_DEPTH);
	assign wr_addr = req.wr_index[PAL_AW-1:0];
	assign rd_addr = req.rd_index[PAL_AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_addr] <= req.wr_color;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			rd_hit_q    <= 1'b0;
		end else begin
			if (wr_ok) begin
				entry_vld_q[wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_hit_q <= rd_ok && entry_vld_q[rd_addr];
			end
		end
	end

	assign rd_color = rd_hit_q ? rd_data_q : '0;

endmodule

[rtl/tga_rle_pixel_decoder_top.sv]
// Targa run-length pixel decoder top level.
//
// Channels:
//   px_in  - one transaction per stream item: palette write, compressed byte or image start.
//   px_out - one transaction per decoded result: colour, repeat count, image done,
//            overflow error.
//   cfg    - register writes (0 pixel format, 1 width, 2 height); always ready.
// Throughput: one input transaction per clock, unless px_in is held by a register write or
//   by a stall at the output. Decode state sits in flops and is updated in the cycle the
//   byte is taken; the palette lookup is the only path through a registered RAM read.
// Path: a result is registered in stage 1 (decode + palette read), then in the output
//   register, before it appears on px_out.
// Config: a write blocks px_in for the following cycle while width * height is
//   re-registered.
// Reset: all control state cleared at once; palette entries read as black until
//   written (per-entry valid bits, no clearing pass).
// Stall: px_out holds its result; px_in keeps taking bytes while the stage ahead of
//   the output register is free or moving, so one result may wait behind it.
module tga_rle_pixel_decoder_top
	import tga_rle_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	tga_rle_in_if.sink  px_in,
	tga_rle_out_if.source px_out,
	tga_rle_cfg_if.sink cfg
);

	// configuration
	logic [1:0]  fmt_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [31:0] total_q;
	logic        fresh_q;

	// decode state
	logic [31:0] pixels_done_q, pixels_done_n;
	logic [7:0]  packet_left_q, packet_left_n;
	logic        is_run_q, is_run_n;
	logic [1:0]  phase_q, phase_n;
	logic [7:0]  held_blue_q, held_blue_n;
	logic [7:0]  held_green_q, held_green_n;
	logic [7:0]  held_red_q, held_red_n;
	logic        stopped_q, stopped_n;

	// result of the item being taken
	logic        res_vld;
	rgb_t        res_rgb;
	logic        res_pal;
	logic [7:0]  res_rep;
	logic        res_done;
	logic        res_err;

	logic        acc;
	logic        s1_adv;
	logic [7:0]  count;
	logic [32:0] sum;
	logic [1:0]  last_phase;
	pal_req_t    pal_req;
	rgb_t        pal_color;

	// stage 1: decoded result waiting for palette data
	logic        valid_s1;
	rgb_t        rgb_s1;
	logic        pal_s1;
	logic [7:0]  rep_s1;
	logic        done_s1;
	logic        err_s1;

	// stage 2: output register
	logic        valid_s2;
	rgb_t        rgb_s2;
	logic [7:0]  rep_s2;
	logic        done_s2;
	logic        err_s2;

	assign s1_adv       = !valid_s2 || px_out.ready;
	assign px_in.ready  = fresh_q && (!valid_s1 || s1_adv);
	assign acc          = px_in.valid && px_in.ready;
	assign cfg.ready    = 1'b1;

	assign count      = {1'b0, px_in.data_byte[6:0] & HDR_COUNT_MASK[6:0]} + 8'd1;
	assign sum        = {1'b0, pixels_done_q} + {25'd0, count};
	assign last_phase = (fmt_q == FMT_GREY || fmt_q == FMT_PAL) ? 2'd0 :
		(fmt_q == FMT_BGR) ? 2'd2 : 2'd3;

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_RESET;
			width_q  <= '0;
			height_q <= '0;
			total_q  <= '0;
			fresh_q  <= 1'b1;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_FORMAT: fmt_q    <= cfg.data[1:0];
					CFG_WIDTH:  width_q  <= cfg.data;
					CFG_HEIGHT: height_q <= cfg.data;
					default: ;
				endcase
			end
			total_q <= width_q * height_q;
			// total is registered from the width and height registers, so it lags them
			fresh_q <= !cfg.valid;
		end
	end

	// ---- decode of the item being taken ----
	always_comb begin
		pixels_done_n = pixels_done_q;
		packet_left_n = packet_left_q;
		is_run_n      = is_run_q;
		phase_n       = phase_q;
		held_blue_n   = held_blue_q;
		held_green_n  = held_green_q;
		held_red_n    = held_red_q;
		stopped_n     = stopped_q;
		res_vld       = 1'b0;
		res_rgb       = '0;
		res_pal       = 1'b0;
		res_rep       = '0;
		res_done      = 1'b0;
		res_err       = 1'b0;
		pal_req.wr_en    = 1'b0;
		pal_req.wr_index = px_in.palette_index;
		pal_req.wr_color = px_in.palette_color;
		pal_req.rd_en    = 1'b0;
		pal_req.rd_index = px_in.data_byte;

		if (acc) begin
			case (px_in.mode)
				MODE_PAL_WR: begin
					pal_req.wr_en = 1'b1;
				end
				MODE_START: begin
					pixels_done_n = '0;
					packet_left_n = '0;
					is_run_n      = 1'b0;
					phase_n       = '0;
					held_blue_n   = '0;
					held_green_n  = '0;
					held_red_n    = '0;
					stopped_n     = 1'b0;
				end
				MODE_DATA: begin
					if (!stopped_q) begin
						if (packet_left_q == 8'd0) begin
							// header; ignored once the image is full
							if (pixels_done_q < total_q) begin
								if (sum > {1'b0, total_q}) begin
									stopped_n = 1'b1;
									res_vld   = 1'b1;
									res_err   = 1'b1;
								end else begin
									pixels_done_n = sum[31:0];
									packet_left_n = count;
									is_run_n      = (px_in.data_byte & HDR_RUN_MASK) != 8'd0;
									phase_n       = '0;
								end
							end
						end else if (phase_q < last_phase) begin
							case (phase_q)
								2'd0:    held_blue_n  = px_in.data_byte;
								2'd1:    held_green_n = px_in.data_byte;
								default: held_red_n   = px_in.data_byte;
							endcase
							phase_n = phase_q + 2'd1;
						end else begin
							// last byte of a pixel (alpha dropped for BGRA)
							case (fmt_q)
								FMT_GREY: begin
									res_rgb = '{px_in.data_byte, px_in.data_byte, px_in.data_byte};
								end
								FMT_PAL: begin
									res_pal       = 1'b1;
									pal_req.rd_en = 1'b1;
								end
								FMT_BGR: begin
									held_red_n = px_in.data_byte;
									res_rgb    = '{px_in.data_byte, held_green_q, held_blue_q};
								end
								default: begin
									res_rgb = '{held_red_q, held_green_q, held_blue_q};
								end
							endcase
							phase_n = '0;
							if (is_run_q) begin
								res_rep       = packet_left_q;
								packet_left_n = '0;
							end else begin
								res_rep       = 8'd1;
								packet_left_n = packet_left_q - 8'd1;
							end
							res_done = (packet_left_n == 8'd0) && (pixels_done_q == total_q);
							if (res_done) begin
								stopped_n = 1'b1;
							end
							res_vld = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_done_q <= '0;
			packet_left_q <= '0;
			is_run_q      <= 1'b0;
			phase_q       <= '0;
			held_blue_q   <= '0;
			held_green_q  <= '0;
			held_red_q    <= '0;
			stopped_q     <= 1'b0;
		end else begin
			pixels_done_q <= pixels_done_n;
			packet_left_q <= packet_left_n;
			is_run_q      <= is_run_n;
			phase_q       <= phase_n;
			held_blue_q   <= held_blue_n;
			held_green_q  <= held_green_n;
			held_red_q    <= held_red_n;
			stopped_q     <= stopped_n;
		end
	end

	// palette read issued with the item; data valid while it sits in stage 1
	tga_rle_palette u_palette (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (pal_req),
		.rd_color (pal_color)
	);

	// ---- stage 1 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= res_vld;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rgb_s1  <= res_rgb;
			pal_s1  <= res_pal;
			rep_s1  <= res_rep;
			done_s1 <= res_done;
			err_s1  <= res_err;
		end
	end

	// ---- stage 2: output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			rgb_s2  <= pal_s1 ? pal_color : rgb_s1;
			rep_s2  <= rep_s1;
			done_s2 <= done_s1;
			err_s2  <= err_s1;
		end
	end

	assign px_out.valid          = valid_s2;
	assign px_out.red            = rgb_s2.red;
	assign px_out.green          = rgb_s2.green;
	assign px_out.blue           = rgb_s2.blue;
	assign px_out.repeat_count   = rep_s2;
	assign px_out.image_done     = done_s2;
	assign px_out.overflow_error = err_s2;

endmodule

[rtl/tga_rle_checker.sv]
// Port-level assertions for the Targa run-length decoder, bound to the top level.
module tga_rle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [7:0] repeat_count,
	input logic       image_done,
	input logic       overflow_error,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// no result during reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(repeat_count) && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue))
		else $error("stalled result changed");

	// overflow result carries no pixels
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_error |-> repeat_count == 8'd0 && !image_done
			&& out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
		else $error("malformed overflow result");

	// pixel results cover 1..128 pixels
	a_rep_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !overflow_error |-> repeat_count != 8'd0 && repeat_count <= 8'd128)
		else $error("repeat count out of range");

	// input blocked in the cycle after a register write
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input taken before area product updated");

endmodule

bind tga_rle_pixel_decoder_top tga_rle_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (px_in.ready),
	.out_valid      (px_out.valid),
	.out_ready      (px_out.ready),
	.out_red        (px_out.red),
	.out_green      (px_out.green),
	.out_blue       (px_out.blue),
	.repeat_count   (px_out.repeat_count),
	.image_done     (px_out.image_done),
	.overflow_error (px_out.overflow_error),
	.cfg_valid      (cfg.valid),
	.cfg_ready      (cfg.ready)
);

[verif/testbench.sv]
// Self-checking testbench for the Targa run-length pixel decoder: stream stimulus, pixel checks.
module testbench
	import tga_rle_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// mode value the decoder has no use for; must be dropped silently
	localparam logic [1:0] MODE_IGNORED = 2'd3;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_ITEMS  = 1700;
	// lets the pipe empty with margin, used before register writes and at the end
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  data_byte;
		logic [7:0]  palette_index;
		logic [23:0] palette_color;
	} stream_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] repeat_count;
		logic       image_done;
		logic       overflow_error;
	} pixel_result_t;

	logic clk;
	logic arst_n;

	tga_rle_in_if  px_in_bus ();
	tga_rle_out_if px_out_bus ();
	tga_rle_cfg_if cfg_bus ();

	tga_rle_pixel_decoder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.px_in  (px_in_bus),
		.px_out (px_out_bus),
		.cfg    (cfg_bus)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Decoder shadow: register copies and decode state, stepped once per
	// accepted input transaction.
	// ------------------------------------------------------------------
	logic [23:0] pal_shadow [PALETTE_DEPTH];
	logic [1:0]  fmt_cfg;
	logic [15:0] width_cfg;
	logic [15:0] height_cfg;
	logic [32:0] pix_count;
	logic [7:0]  pkt_remaining;
	logic        pkt_run;
	logic [1:0]  byte_pos;
	logic [7:0]  held_b;
	logic [7:0]  held_g;
	logic [7:0]  held_r;
	logic        halted;

	function automatic void clear_decode();
		pix_count     = '0;
		pkt_remaining = '0;
		pkt_run       = 1'b0;
		byte_pos      = '0;
		held_b        = '0;
		held_g        = '0;
		held_r        = '0;
		halted        = 1'b0;
	endfunction

	// Returns 1 when the transaction yields a pixel (or overflow) result.
	function automatic bit decode_byte(input stream_item_t it, output pixel_result_t res);
		logic [32:0] total;
		logic [8:0]  count;
		logic [1:0]  last_pos;
		logic [23:0] colour;
		total = 33'(width_cfg) * 33'(height_cfg);
		res = '0;
		if (it.mode == MODE_PAL_WR) begin
			if (int'(it.palette_index) < PALETTE_DEPTH)
				pal_shadow[it.palette_index] = it.palette_color;
			return 1'b0;
		end
		if (it.mode == MODE_START) begin
			clear_decode();
			return 1'b0;
		end
		if (it.mode != MODE_DATA || halted)
			return 1'b0;

		// packet header
		if (pkt_remaining == 0) begin
			count = 9'(it.data_byte & HDR_COUNT_MASK) + 9'd1;
			if (pix_count >= total)
				return 1'b0;
			if (pix_count + 33'(count) > total) begin
				halted = 1'b1;
				res.overflow_error = 1'b1;
				return 1'b1;
			end
			pix_count     += 33'(count);
			pkt_remaining = count[7:0];
			pkt_run       = |(it.data_byte & HDR_RUN_MASK);
			byte_pos      = '0;
			return 1'b0;
		end

		case (fmt_cfg)
			FMT_GREY, FMT_PAL: last_pos = 2'd0;
			FMT_BGR:           last_pos = 2'd2;
			default:           last_pos = 2'd3;
		endcase

		// pixel byte that does not yet finish the pixel
		if (byte_pos < last_pos) begin
			case (byte_pos)
				2'd0:    held_b = it.data_byte;
				2'd1:    held_g = it.data_byte;
				default: held_r = it.data_byte;
			endcase
			byte_pos = byte_pos + 2'd1;
			return 1'b0;
		end

		case (fmt_cfg)
			FMT_GREY: begin
				res.red   = it.data_byte;
				res.green = it.data_byte;
				res.blue  = it.data_byte;
			end
			FMT_PAL: begin
				colour = (int'(it.data_byte) < PALETTE_DEPTH) ? pal_shadow[it.data_byte] : '0;
				res.red   = colour[23:16];
				res.green = colour[15:8];
				res.blue  = colour[7:0];
			end
			FMT_BGR: begin
				held_r    = it.data_byte;
				res.red   = held_r;
				res.green = held_g;
				res.blue  = held_b;
			end
			default: begin
				// alpha byte is dropped
				res.red   = held_r;
				res.green = held_g;
				res.blue  = held_b;
			end
		endcase
		byte_pos = '0;

		if (pkt_run) begin
			res.repeat_count = pkt_remaining;
			pkt_remaining    = '0;
		end else begin
			res.repeat_count = 8'd1;
			pkt_remaining    = pkt_remaining - 8'd1;
		end
		res.image_done = (pkt_remaining == 0 && pix_count == total);
		if (res.image_done)
			halted = 1'b1;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Shared bookkeeping
	// ------------------------------------------------------------------
	stream_item_t  feed_q [$];
	pixel_result_t pending_pixels [$];
	int unsigned   fed_count;
	int unsigned   taken_count;
	int unsigned   cycle_count;
	bit            failed;
	bit            steady;     // no idling on either side while set
	bit            hold_off;   // long receiver stall

	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// ------------------------------------------------------------------
	// Input driver: presents queued items at the falling edge, counts a
	// transaction at the rising edge where valid and ready meet.
	// ------------------------------------------------------------------
	stream_item_t on_bus;
	bit           in_taken;
	int           in_gap;

	always @(posedge clk) begin
		pixel_result_t res;
		if (arst_n && px_in_bus.valid && px_in_bus.ready) begin
			if (decode_byte(on_bus, res))
				pending_pixels.push_back(res);
			taken_count++;
			in_taken = 1'b1;
			in_gap = pick_gap();
		end
	end

	always @(negedge clk) begin
		if (arst_n && (in_taken || !px_in_bus.valid)) begin
			in_taken = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				px_in_bus.valid <= 1'b0;
			end else if (feed_q.size() != 0) begin
				on_bus = feed_q.pop_front();
				px_in_bus.valid         <= 1'b1;
				px_in_bus.mode          <= on_bus.mode;
				px_in_bus.data_byte     <= on_bus.data_byte;
				px_in_bus.palette_index <= on_bus.palette_index;
				px_in_bus.palette_color <= on_bus.palette_color;
			end else begin
				px_in_bus.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output monitor: checks each result transaction against the oldest
	// predicted pixel; ready is varied at the falling edge.
	// ------------------------------------------------------------------
	int out_gap;

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && px_out_bus.valid && px_out_bus.ready) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel result with nothing predicted: rgb %h%h%h rep %0d",
					px_out_bus.red, px_out_bus.green, px_out_bus.blue, px_out_bus.repeat_count);
				failed = 1'b1;
			end else begin
				want = pending_pixels.pop_front();
				check_field("red", want.red, px_out_bus.red);
				check_field("green", want.green, px_out_bus.green);
				check_field("blue", want.blue, px_out_bus.blue);
				check_field("repeat_count", want.repeat_count, px_out_bus.repeat_count);
				check_field("image_done", 8'(want.image_done), 8'(px_out_bus.image_done));
				check_field("overflow_error", 8'(want.overflow_error),
					8'(px_out_bus.overflow_error));
			end
			out_gap = pick_gap();
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off) begin
				px_out_bus.ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				px_out_bus.ready <= 1'b0;
			end else begin
				px_out_bus.ready <= 1'b1;
			end
		end
	end

	// Back-pressure: once traffic is flowing with plenty queued, the
	// receiver stops taking results so the decoder fills and stalls px_in.
	initial begin
		hold_off = 1'b0;
		while (!(taken_count >= 600 && feed_q.size() > 40))
			@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tga_rle_pixel_decoder_top verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic feed(input logic [1:0] mode, input logic [7:0] data_byte,
		input logic [7:0] pal_index, input logic [23:0] colour);
		stream_item_t it;
		it.mode          = mode;
		it.data_byte     = data_byte;
		it.palette_index = pal_index;
		it.palette_color = colour;
		feed_q.push_back(it);
		fed_count++;
	endtask

	// compressed byte; the unused fields carry noise
	task automatic feed_data(input logic [7:0] data_byte);
		feed(MODE_DATA, data_byte, 8'($urandom_range(0, 255)), 24'($urandom));
	endtask

	task automatic feed_palette();
		feed(MODE_PAL_WR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			24'($urandom));
	endtask

	// Register write on the cfg channel; the shadow copy follows on acceptance.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			CFG_FORMAT: fmt_cfg    = value[1:0];
			CFG_WIDTH:  width_cfg  = value;
			CFG_HEIGHT: height_cfg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Wait until every queued transaction is taken and every pixel checked,
	// then let the pipe empty of anything still in flight.
	task automatic drain();
		while (taken_count != fed_count)
			@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Random phase: new geometry and format, then a mostly well-formed
	// packet stream sprinkled with noise. Sometimes only the format moves
	// and the old stream carries on, possibly mid-pixel.
	// ------------------------------------------------------------------
	longint unsigned stream_left;

	task automatic random_phase();
		logic [1:0]  fmt;
		logic [15:0] w;
		logic [15:0] h;
		longint unsigned cap;
		int  budget;
		int  count;
		int  n_bytes;
		int  bytes_per_px;
		int  roll;
		bit  carry_on;
		bit  cut;
		bit  run;
		drain();
		steady   = ($urandom_range(0, 4) == 0);
		fmt      = 2'($urandom_range(0, 3));
		carry_on = ($urandom_range(0, 4) == 0);
		cut      = ($urandom_range(0, 2) == 0);
		write_reg(CFG_FORMAT, {14'd0, fmt});
		if (!carry_on) begin
			case ($urandom_range(0, 9))
				0: begin
					// empty image in one direction or both
					w = 16'($urandom_range(0, 3));
					h = (w == 0) ? 16'($urandom_range(0, 4)) : 16'd0;
				end
				1: begin
					w = 16'hFFFF;
					h = 16'hFFFF;
					if ($urandom_range(0, 1)) begin
						if ($urandom_range(0, 1))
							w = 16'd1;
						else
							h = 16'd1;
					end
				end
				default: begin
					w = 16'($urandom_range(1, 8));
					h = 16'($urandom_range(1, 6));
				end
			endcase
			write_reg(CFG_WIDTH, w);
			write_reg(CFG_HEIGHT, h);
			repeat ($urandom_range(0, (fmt == FMT_PAL) ? 8 : 2)) feed_palette();
			feed(MODE_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				24'($urandom));
			stream_left = longint'(w) * longint'(h);
		end

		bytes_per_px = (fmt == FMT_BGRA) ? 4 : ((fmt == FMT_BGR) ? 3 : 1);
		budget = $urandom_range(20, 90);
		while (budget > 0 && stream_left != 0) begin
			roll = $urandom_range(0, 59);
			if (roll == 0) begin
				// restart in the middle of things; geometry unchanged
				feed(MODE_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					24'($urandom));
				stream_left = longint'(width_cfg) * longint'(height_cfg);
			end else if (roll < 4) begin
				if ($urandom_range(0, 1))
					feed_palette();
				else
					feed(MODE_IGNORED, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 24'($urandom));
			end else begin
				cap = (stream_left < 128) ? stream_left : 128;
				if ($urandom_range(0, 24) == 0)
					count = $urandom_range(1, 128);   // may overflow
				else if ($urandom_range(0, 3) == 0)
					count = $urandom_range(1, int'(cap));
				else
					count = $urandom_range(1, (cap < 4) ? int'(cap) : 4);
				run = 1'($urandom_range(0, 1));
				feed_data({run, 7'(count - 1)});
				budget--;
				if (longint'(count) > stream_left) begin
					stream_left = 0;   // decoder halts on overflow
				end else begin
					stream_left -= longint'(count);
					n_bytes = (run ? 1 : count) * bytes_per_px;
					for (int i = 0; i < n_bytes; i++) begin
						if (cut && budget <= 0)
							break;
						feed_data(8'($urandom_range(0, 255)));
						budget--;
					end
				end
			end
		end
		// bytes past the end of the image or on an empty one
		repeat ($urandom_range(0, 4)) feed_data(8'($urandom_range(0, 255)));
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n                  = 1'b0;
		px_in_bus.valid         = 1'b0;
		px_in_bus.mode          = MODE_PAL_WR;
		px_in_bus.data_byte     = '0;
		px_in_bus.palette_index = '0;
		px_in_bus.palette_color = '0;
		px_out_bus.ready        = 1'b0;
		cfg_bus.valid           = 1'b0;
		cfg_bus.index           = CFG_FORMAT;
		cfg_bus.data            = '0;
		fed_count    = 0;
		taken_count  = 0;
		cycle_count  = 0;
		stream_left  = 0;
		failed       = 1'b0;
		steady       = 1'b0;
		in_taken     = 1'b0;
		in_gap       = 0;
		out_gap      = 0;
		fmt_cfg      = FMT_RESET;
		width_cfg    = '0;
		height_cfg   = '0;
		foreach (pal_shadow[i])
			pal_shadow[i] = '0;
		clear_decode();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset geometry is 0 x 0: a header finds no room and is dropped
		feed_data(HDR_RUN_MASK | 8'h05);
		feed(MODE_IGNORED, 8'hFF, 8'hFF, 24'hFFFFFF);
		drain();

		// palette mode, 2 x 2 image
		write_reg(CFG_FORMAT, {14'd0, FMT_PAL});
		write_reg(CFG_WIDTH, 16'd2);
		write_reg(CFG_HEIGHT, 16'd2);
		feed(MODE_PAL_WR, 8'h00, 8'h00, 24'hFFFFFF);
		feed(MODE_PAL_WR, 8'hFF, 8'hFF, 24'h123456);
		feed(MODE_START, 8'h00, 8'h00, 24'h000000);
		feed_data(8'h81);   // run of two
		feed_data(8'hFF);   // top palette entry
		feed_data(8'h00);   // literal of one
		feed_data(8'h00);
		feed_data(8'h7F);   // 128 pixels into one free slot: overflow
		feed_data(8'h00);   // halted, dropped
		feed(MODE_START, 8'h00, 8'h00, 24'h000000);
		feed_data(8'h83);   // run of four fills the image
		feed_data(8'h07);   // never-written entry reads black
		feed_data(8'h5A);   // image complete, dropped
		drain();

		// widest geometry, BGRA; format drops to BGR after blue and green
		write_reg(CFG_FORMAT, {14'd0, FMT_BGRA});
		write_reg(CFG_WIDTH, 16'hFFFF);
		write_reg(CFG_HEIGHT, 16'hFFFF);
		feed(MODE_START, 8'hFF, 8'hFF, 24'hFFFFFF);
		feed_data(8'hFF);   // run of 128
		feed_data(8'h00);
		feed_data(8'hFF);
		drain();
		write_reg(CFG_FORMAT, {14'd0, FMT_BGR});
		feed_data(8'hA5);   // red byte finishes the pixel
		feed_data(8'h01);   // literal of two
		feed_data(8'h11);
		drain();
		// one byte already held, grey needs none: next byte finishes
		write_reg(CFG_FORMAT, {14'd0, FMT_GREY});
		feed_data(8'h5A);
		feed_data(8'h3C);

		while (fed_count < RANDOM_ITEMS)
			random_phase();

		drain();
		if (!failed)
			$display("tga_rle_pixel_decoder_top verification clean");
		else
			$display("tga_rle_pixel_decoder_top verification failed");
		$finish;
	end

endmodule

[tga_rle_pixel_decoder_top.f]
rtl/tga_rle_pkg.sv
rtl/tga_rle_if.sv
rtl/tga_rle_palette.sv
rtl/tga_rle_pixel_decoder_top.sv
rtl/tga_rle_checker.sv
verif/testbench.sv
